// File: design/mdsp_pkg.sv
`default_nettype none

package mdsp_pkg;

	localparam int SOURCES    = 9;
	localparam int RING_DEPTH = 8192;
	localparam int AW         = $clog2(RING_DEPTH);
	localparam int SRC_W      = $clog2(SOURCES);
	localparam int SAMPLE_W   = 24;
	localparam int GAIN_W     = 16;
	localparam int ACC_W      = 28;
	localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
	localparam int GAIN_FRAC  = 12;

	localparam logic REQ_FRAME = 1'b0;
	localparam logic REQ_COEF  = 1'b1;

	typedef enum logic [1:0] {
		KIND_DELAY_L = 2'd0,
		KIND_DELAY_R = 2'd1,
		KIND_GAIN_L  = 2'd2,
		KIND_GAIN_R  = 2'd3
	} coef_kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_OUT_RD,
		ST_OUT_WR
	} state_t;

	typedef struct packed {
		logic                       req_type;
		logic [5:0]                 coef_index;
		logic [15:0]                coef_value;
		logic signed [SAMPLE_W-1:0] sample_0;
		logic signed [SAMPLE_W-1:0] sample_1;
		logic signed [SAMPLE_W-1:0] sample_2;
		logic signed [SAMPLE_W-1:0] sample_3;
		logic signed [SAMPLE_W-1:0] sample_4;
		logic signed [SAMPLE_W-1:0] sample_5;
		logic signed [SAMPLE_W-1:0] sample_6;
		logic signed [SAMPLE_W-1:0] sample_7;
		logic signed [SAMPLE_W-1:0] sample_8;
	} in_req_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_left;
		logic signed [SAMPLE_W-1:0] out_right;
	} out_item_t;

	// pick one source's sample out of the frame
	function automatic logic signed [SAMPLE_W-1:0] sample_sel(in_req_t r,
			logic [SRC_W-1:0] s);
		logic signed [SAMPLE_W-1:0] v;
		unique case (s)
			1:       v = r.sample_1;
			2:       v = r.sample_2;
			3:       v = r.sample_3;
			4:       v = r.sample_4;
			5:       v = r.sample_5;
			6:       v = r.sample_6;
			7:       v = r.sample_7;
			8:       v = r.sample_8;
			default: v = r.sample_0;
		endcase
		return v;
	endfunction

	// (base + delay) modulo ring depth
	function automatic logic [AW-1:0] ring_addr(logic [AW-1:0] base,
			logic [AW-1:0] delay);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, delay};
		if (sum >= (AW+1)'(RING_DEPTH)) begin
			sum = sum - (AW+1)'(RING_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_acc(logic signed [ACC_W:0] v);
		logic signed [ACC_W-1:0] r;
		if (v[ACC_W] != v[ACC_W-1]) begin
			r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r = v[ACC_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_out(logic signed [ACC_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v[ACC_W-1:SAMPLE_W-1] != {(ACC_W-SAMPLE_W+1){v[ACC_W-1]}}) begin
			r = v[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
				: {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/multichannel_delay_sum_panner.sv
`default_nettype none

// Delay-and-sum stereo panner for up to nine sources. Each sample frame
// request adds every source's sample, scaled by its left and right Q4.12
// gain, into two 8192-entry ring accumulators at the ring pointer plus that
// side's delay, then returns the entries at the pointer (saturated to 24 bits)
// as one result, clears them and advances the pointer. A coefficient request
// loads one delay (clipped to ring depth - 1) or one gain and returns nothing.
// The rings live in two single-port-style synchronous memories (one read,
// one write per cycle, registered read); each source is one read-modify-write
// of both rings, so a frame occupies the block from its accept through a
// read and a write state per source and then an output read and write
// state, and a coefficient request is applied when it is accepted. A
// finished result waits in an output register, so the next request is
// accepted while it is held; the block only stalls at the end of a frame if
// the previous result has not been taken. After reset a clearing pass writes
// zero to every ring entry, during which in_ready stays low.
module multichannel_delay_sum_panner (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire mdsp_pkg::in_req_t   in_req,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      mdsp_pkg::out_item_t out_item
);

	localparam int AW     = mdsp_pkg::AW;
	localparam int SRC_W  = mdsp_pkg::SRC_W;
	localparam int ACC_W  = mdsp_pkg::ACC_W;
	localparam int GAIN_W = mdsp_pkg::GAIN_W;
	localparam int SMP_W  = mdsp_pkg::SAMPLE_W;
	localparam int PROD_W = mdsp_pkg::PROD_W;

	// control state
	mdsp_pkg::state_t state_q, state_d;
	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    ptr_q;
	logic [SRC_W-1:0] src_q;
	logic             out_valid_q;

	// coefficient tables, one entry per source and side
	logic [AW-1:0]     delay_l_q [mdsp_pkg::SOURCES];
	logic [AW-1:0]     delay_r_q [mdsp_pkg::SOURCES];
	logic [GAIN_W-1:0] gain_l_q  [mdsp_pkg::SOURCES];
	logic [GAIN_W-1:0] gain_r_q  [mdsp_pkg::SOURCES];

	// held frame and per-source datapath
	mdsp_pkg::in_req_t        frame_q;
	logic signed [ACC_W-1:0]  prod_l_s1, prod_r_s1;
	logic [AW-1:0]            waddr_l_q, waddr_r_q;
	mdsp_pkg::out_item_t      out_q;

	// ring memories
	logic signed [ACC_W-1:0] left_mem  [mdsp_pkg::RING_DEPTH];
	logic signed [ACC_W-1:0] right_mem [mdsp_pkg::RING_DEPTH];
	logic signed [ACC_W-1:0] rdata_l_q, rdata_r_q;

	// memory port controls
	logic                    rd_en;
	logic [AW-1:0]           raddr_l, raddr_r;
	logic                    wr_en;
	logic [AW-1:0]           waddr_l, waddr_r;
	logic signed [ACC_W-1:0] wdata_l, wdata_r;

	// combinational helpers
	logic                    accept;
	logic                    out_free;
	logic signed [SMP_W-1:0] cur_sample;
	logic signed [PROD_W-1:0] mul_l, mul_r;
	logic [AW-1:0]           addr_l, addr_r;
	logic [SRC_W:0]          coef_src;
	logic [1:0]              coef_kind;
	logic [AW-1:0]           coef_delay;
	logic [AW-1:0]           ptr_next;

	assign in_ready  = (state_q == mdsp_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// current source: gain products and ring addresses
	assign cur_sample = mdsp_pkg::sample_sel(frame_q, src_q);
	assign mul_l      = cur_sample * $signed({1'b0, gain_l_q[src_q]});
	assign mul_r      = cur_sample * $signed({1'b0, gain_r_q[src_q]});
	assign addr_l     = mdsp_pkg::ring_addr(ptr_q, delay_l_q[src_q]);
	assign addr_r     = mdsp_pkg::ring_addr(ptr_q, delay_r_q[src_q]);
	assign ptr_next   = (ptr_q == AW'(mdsp_pkg::RING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;

	// coefficient decode, delay clipped to the ring
	assign coef_src  = {1'b0, in_req.coef_index[5:2]};
	assign coef_kind = in_req.coef_index[1:0];
	assign coef_delay = ({1'b0, in_req.coef_value} > 17'(mdsp_pkg::RING_DEPTH - 1))
		? AW'(mdsp_pkg::RING_DEPTH - 1) : in_req.coef_value[AW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mdsp_pkg::ST_CLEAR: begin
				if (clr_q == AW'(mdsp_pkg::RING_DEPTH - 1)) begin
					state_d = mdsp_pkg::ST_IDLE;
				end
			end
			mdsp_pkg::ST_IDLE: begin
				if (accept && in_req.req_type == mdsp_pkg::REQ_FRAME) begin
					state_d = mdsp_pkg::ST_MUL;
				end
			end
			mdsp_pkg::ST_MUL: begin
				state_d = mdsp_pkg::ST_ACC;
			end
			mdsp_pkg::ST_ACC: begin
				if (src_q == SRC_W'(mdsp_pkg::SOURCES - 1)) begin
					state_d = mdsp_pkg::ST_OUT_RD;
				end else begin
					state_d = mdsp_pkg::ST_MUL;
				end
			end
			mdsp_pkg::ST_OUT_RD: begin
				state_d = mdsp_pkg::ST_OUT_WR;
			end
			mdsp_pkg::ST_OUT_WR: begin
				if (out_free) begin
					state_d = mdsp_pkg::ST_IDLE;
				end
			end
			default: state_d = mdsp_pkg::ST_CLEAR;
		endcase
	end

	// memory port controls per state
	always_comb begin
		rd_en   = 1'b0;
		raddr_l = addr_l;
		raddr_r = addr_r;
		wr_en   = 1'b0;
		waddr_l = waddr_l_q;
		waddr_r = waddr_r_q;
		wdata_l = mdsp_pkg::sat_acc({rdata_l_q[ACC_W-1], rdata_l_q}
			+ {prod_l_s1[ACC_W-1], prod_l_s1});
		wdata_r = mdsp_pkg::sat_acc({rdata_r_q[ACC_W-1], rdata_r_q}
			+ {prod_r_s1[ACC_W-1], prod_r_s1});
		unique case (state_q)
			mdsp_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				waddr_l = clr_q;
				waddr_r = clr_q;
				wdata_l = '0;
				wdata_r = '0;
			end
			mdsp_pkg::ST_MUL: begin
				// read the targets of this source; the previous source's write is already in memory
				rd_en = 1'b1;
			end
			mdsp_pkg::ST_ACC: begin
				wr_en = 1'b1;
			end
			mdsp_pkg::ST_OUT_RD: begin
				rd_en   = 1'b1;
				raddr_l = ptr_q;
				raddr_r = ptr_q;
			end
			mdsp_pkg::ST_OUT_WR: begin
				// clear the emitted entries once the result is handed over
				wr_en   = out_free;
				waddr_l = ptr_q;
				waddr_r = ptr_q;
				wdata_l = '0;
				wdata_r = '0;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mdsp_pkg::ST_CLEAR;
			clr_q       <= '0;
			ptr_q       <= '0;
			src_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mdsp_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				src_q <= '0;
			end else if (state_q == mdsp_pkg::ST_ACC) begin
				src_q <= src_q + 1'b1;
			end
			if (state_q == mdsp_pkg::ST_OUT_WR && out_free) begin
				out_valid_q <= 1'b1;
				ptr_q       <= ptr_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// coefficient tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mdsp_pkg::SOURCES; i++) begin
				delay_l_q[i] <= '0;
				delay_r_q[i] <= '0;
				gain_l_q[i]  <= '0;
				gain_r_q[i]  <= '0;
			end
		end else if (accept && in_req.req_type == mdsp_pkg::REQ_COEF
				&& coef_src < (SRC_W+1)'(mdsp_pkg::SOURCES)) begin
			unique case (coef_kind)
				mdsp_pkg::KIND_DELAY_L: delay_l_q[coef_src[SRC_W-1:0]] <= coef_delay;
				mdsp_pkg::KIND_DELAY_R: delay_r_q[coef_src[SRC_W-1:0]] <= coef_delay;
				mdsp_pkg::KIND_GAIN_L:  gain_l_q[coef_src[SRC_W-1:0]]  <= in_req.coef_value;
				default:                gain_r_q[coef_src[SRC_W-1:0]]  <= in_req.coef_value;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			frame_q <= in_req;
		end
		if (state_q == mdsp_pkg::ST_MUL) begin
			// floor of product / 4096
			prod_l_s1 <= mul_l[mdsp_pkg::GAIN_FRAC +: ACC_W];
			prod_r_s1 <= mul_r[mdsp_pkg::GAIN_FRAC +: ACC_W];
			waddr_l_q <= addr_l;
			waddr_r_q <= addr_r;
		end
		if (state_q == mdsp_pkg::ST_OUT_WR && out_free) begin
			out_q.out_left  <= mdsp_pkg::sat_out(rdata_l_q);
			out_q.out_right <= mdsp_pkg::sat_out(rdata_r_q);
		end
	end

	// ring memories, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			left_mem[waddr_l]  <= wdata_l;
			right_mem[waddr_r] <= wdata_r;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_l_q <= left_mem[raddr_l];
			rdata_r_q <= right_mem[raddr_r];
		end
	end

endmodule

`default_nettype wire
